// File: rtl/core/lpd_pkg.sv
// lpd_pkg: shared constants and types for the length-prefix deframer
// depends on nothing; imported by every module in rtl/core
`default_nettype none

package lpd_pkg;

	// bytes in the little-endian length header
	localparam int LENGTH_BYTES = 4;
	// header bytes that land in the 32-bit length word
	localparam int ACCUM_BYTES = (LENGTH_BYTES < 4) ? LENGTH_BYTES : 4;
	localparam int HDR_CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

	localparam logic [31:0] MAX_FRAME_RESET = 32'd1048576;
	localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(LENGTH_BYTES - 1);

	// one result item
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_of_frame;
		logic       empty_frame;
		logic       frame_error;
	} lpd_res_t;

	// stage-1 item handed to the frame tracker
	typedef struct packed {
		logic       valid;
		logic       advance;
		logic [7:0] data;
	} lpd_item_t;

endpackage

`default_nettype wire

// File: rtl/core/length_prefix_deframer_top.sv
// length_prefix_deframer_top: input register, frame tracker and output buffer
// depends on lpd_pkg, lpd_frame_fsm, lpd_skid
//
// Usage:
//   Raw link bytes enter on in_valid/in_ready/data_byte. Each frame is a
//   4-byte little-endian length followed by that many payload bytes.
//   Results leave on out_valid/out_ready with payload_byte, last_of_frame,
//   empty_frame and frame_error. Header bytes give no result except an
//   empty-frame or error result on the final length byte.
//   Throughput is one byte per cycle while in_ready stays high; the per-byte
//   work is a 32-bit countdown and one length compare between the input
//   register and the output buffer. A byte's result is registered in the
//   output buffer after the byte has been held in the input register.
//   A stalled receiver is absorbed by a two-entry output buffer; in_ready
//   drops only once both entries are full and the input register holds a
//   byte that makes a result.
//   cfg_wr_en/cfg_wr_data write max_frame_bytes (reset 1048576); write it
//   only while the block is idle. A length above it gives one error result,
//   and every later byte is consumed silently until reset.
//   arst_n clears all frame state and empties both stages.
`default_nettype none

module length_prefix_deframer_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_wr_en,
	input  wire [31:0] cfg_wr_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [7:0]  data_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] payload_byte,
	output logic       last_of_frame,
	output logic       empty_frame,
	output logic       frame_error
);
	import lpd_pkg::*;

	logic [31:0] max_frame_bytes_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        has_result;
	logic        buf_ready;
	logic        fire_s1;
	lpd_item_t   item;
	lpd_res_t    result;
	lpd_res_t    out_res;

	assign fire_s1 = valid_s1 && (!has_result || buf_ready);
	assign in_ready = !valid_s1 || fire_s1;

	assign item.valid = valid_s1;
	assign item.advance = fire_s1;
	assign item.data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= MAX_FRAME_RESET;
		end else if (cfg_wr_en) begin
			max_frame_bytes_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1 <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			data_s1 <= data_byte;
		end
	end

	lpd_frame_fsm u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.max_frame_bytes(max_frame_bytes_q),
		.has_result     (has_result),
		.result         (result)
	);

	lpd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(valid_s1 && has_result),
		.push_res  (result),
		.push_ready(buf_ready),
		.pop_valid (out_valid),
		.pop_res   (out_res),
		.pop_ready (out_ready)
	);

	assign payload_byte = out_res.payload_byte;
	assign last_of_frame = out_res.last_of_frame;
	assign empty_frame = out_res.empty_frame;
	assign frame_error = out_res.frame_error;

endmodule

`default_nettype wire

// File: rtl/core/lpd_frame_fsm.sv
// lpd_frame_fsm: header assembly, payload countdown and error latch
// depends on lpd_pkg
`default_nettype none

module lpd_frame_fsm (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire lpd_pkg::lpd_item_t item,
	input  wire [31:0]              max_frame_bytes,
	output logic                    has_result,
	output lpd_pkg::lpd_res_t       result
);
	import lpd_pkg::*;

	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [31:0]          len_acc_q;
	logic                 len_high_q;
	logic [31:0]          remaining_q;
	logic                 in_payload_q;
	logic                 broken_q;

	logic [31:0] len_now;
	logic        high_now;
	logic        hdr_done;
	logic        oversize;
	logic [31:0] remaining_dec;

	always_comb begin
		len_now = len_acc_q;
		high_now = len_high_q;
		for (int i = 0; i < ACCUM_BYTES; i++) begin
			if (32'(hdr_cnt_q) == 32'(i)) begin
				len_now[8*i +: 8] = item.data;
			end
		end
		// bytes beyond the fourth must be zero to fit in 32 bits
		if (32'(hdr_cnt_q) >= 32'(ACCUM_BYTES) && item.data != 8'd0) begin
			high_now = 1'b1;
		end
		hdr_done = (hdr_cnt_q == HDR_LAST);
		oversize = high_now || (len_now > max_frame_bytes);
		remaining_dec = remaining_q - 32'd1;
	end

	always_comb begin
		has_result = 1'b0;
		result = '0;
		if (item.valid && !broken_q) begin
			if (in_payload_q) begin
				has_result = 1'b1;
				result.payload_byte = item.data;
				result.last_of_frame = (remaining_dec == 32'd0);
			end else if (hdr_done) begin
				if (oversize) begin
					has_result = 1'b1;
					result.frame_error = 1'b1;
				end else if (len_now == 32'd0) begin
					has_result = 1'b1;
					result.last_of_frame = 1'b1;
					result.empty_frame = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			len_acc_q <= '0;
			len_high_q <= 1'b0;
			remaining_q <= '0;
			in_payload_q <= 1'b0;
			broken_q <= 1'b0;
		end else if (item.advance && !broken_q) begin
			if (in_payload_q) begin
				remaining_q <= remaining_dec;
				if (remaining_dec == 32'd0) begin
					in_payload_q <= 1'b0;
				end
			end else if (hdr_done) begin
				hdr_cnt_q <= '0;
				len_acc_q <= '0;
				len_high_q <= 1'b0;
				if (oversize) begin
					broken_q <= 1'b1;
				end else if (len_now != 32'd0) begin
					in_payload_q <= 1'b1;
					remaining_q <= len_now;
				end
			end else begin
				hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
				len_acc_q <= len_now;
				len_high_q <= high_now;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lpd_skid.sv
// lpd_skid: two-entry output buffer so the result side can stall without
// blocking the next transfer; depends on lpd_pkg
`default_nettype none

module lpd_skid (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push_valid,
	input  wire lpd_pkg::lpd_res_t push_res,
	output logic                   push_ready,
	output logic                   pop_valid,
	output lpd_pkg::lpd_res_t      pop_res,
	input  wire                    pop_ready
);
	import lpd_pkg::*;

	logic     main_valid_q;
	lpd_res_t main_q;
	logic     spare_valid_q;
	lpd_res_t spare_q;

	assign push_ready = !spare_valid_q;
	assign pop_valid = main_valid_q;
	assign pop_res = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			spare_valid_q <= 1'b0;
			main_q <= '0;
			spare_q <= '0;
		end else if (!main_valid_q || pop_ready) begin
			if (spare_valid_q) begin
				main_q <= spare_q;
				main_valid_q <= 1'b1;
				spare_valid_q <= 1'b0;
			end else begin
				main_q <= push_res;
				main_valid_q <= push_valid;
			end
		end else if (push_valid && !spare_valid_q) begin
			// main is stalled, park the new result
			spare_q <= push_res;
			spare_valid_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: tb/length_prefix_deframer_top_test.sv
// length_prefix_deframer_top_test: self-checking bench for the length-prefix deframer
// drives framed byte streams with random pacing, predicts every result in a scoreboard
// depends on lpd_pkg and length_prefix_deframer_top

module length_prefix_deframer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned LONG_HOLD = 80;
	// margin for the input register and the output buffer to empty
	localparam int unsigned SETTLE_CYCLES = 6;

	typedef enum int unsigned {
		RX_FREE,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SLOW
	} rx_mode_e;

	// tracks frame state and holds the results still owed by the block
	class frame_scoreboard;
		lpd_res_t    expected_q[$];
		logic [31:0] max_len;
		int unsigned hdr_count;
		logic [31:0] len_accum;
		bit          len_high;
		logic [31:0] remaining;
		bit          in_payload;
		bit          broken;
		int unsigned errors;

		function new();
			max_len = MAX_FRAME_RESET;
			hdr_count = 0;
			len_accum = '0;
			len_high = 1'b0;
			remaining = '0;
			in_payload = 1'b0;
			broken = 1'b0;
			errors = 0;
		endfunction

		function void set_max(logic [31:0] v);
			max_len = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void add_expected(lpd_res_t r);
			expected_q = {expected_q, r};
		endfunction

		function void note_byte(logic [7:0] b);
			logic [31:0] len;
			bit          high;
			if (broken)
				return;
			if (in_payload) begin
				remaining = remaining - 1;
				add_expected(lpd_res_t'{b, remaining == 0, 1'b0, 1'b0});
				if (remaining == 0)
					in_payload = 1'b0;
				return;
			end
			if (hdr_count < 4)
				len_accum |= 32'(b) << (8 * hdr_count);
			else if (b != 8'h00)
				len_high = 1'b1;
			hdr_count++;
			if (hdr_count < LENGTH_BYTES)
				return;
			len = len_accum;
			high = len_high;
			hdr_count = 0;
			len_accum = '0;
			len_high = 1'b0;
			if (high || len > max_len) begin
				// oversize length kills the stream for good
				broken = 1'b1;
				add_expected(lpd_res_t'{8'h00, 1'b0, 1'b0, 1'b1});
			end else if (len == 0) begin
				add_expected(lpd_res_t'{8'h00, 1'b1, 1'b1, 1'b0});
			end else begin
				in_payload = 1'b1;
				remaining = len;
			end
		endfunction

		function void check_result(lpd_res_t got);
			lpd_res_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result byte=%02h last=%b empty=%b err=%b", $time,
					got.payload_byte, got.last_of_frame, got.empty_frame, got.frame_error);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected byte=%02h last=%b empty=%b err=%b", $time,
					want.payload_byte, want.last_of_frame, want.empty_frame, want.frame_error);
				$display("%0t:          actual   byte=%02h last=%b empty=%b err=%b", $time,
					got.payload_byte, got.last_of_frame, got.empty_frame, got.frame_error);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  payload_byte;
	logic        last_of_frame;
	logic        empty_frame;
	logic        frame_error;

	frame_scoreboard board;
	bit              hold_request;
	int unsigned     burst_left;
	int unsigned     byte_count;
	int unsigned     cycle_count;

	length_prefix_deframer_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.last_of_frame (last_of_frame),
		.empty_frame   (empty_frame),
		.frame_error   (frame_error)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: checks each transfer and stalls on its own changing pattern
	initial begin
		int unsigned hold_left;
		int unsigned mode_left;
		rx_mode_e    mode;
		hold_left = 0;
		mode_left = 0;
		mode = RX_FREE;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result({payload_byte, last_of_frame, empty_frame, frame_error});
			if (mode_left == 0) begin
				mode = rx_mode_e'($urandom_range(RX_FREE, RX_SLOW));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_FREE:     out_ready <= 1'b1;
					RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: out_ready <= (mode_left % 3) != 0;
					default:     out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// sender gaps come between bursts of random length
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 20);
		gap = $urandom_range(1, 6);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		board.note_byte(b);
		byte_count++;
		pace();
	endtask

	task automatic send_header(input logic [31:0] len);
		for (int i = 0; i < LENGTH_BYTES; i++)
			send_byte(8'(len >> (8 * i)));
	endtask

	task automatic send_frame(input logic [31:0] len);
		logic [7:0] b;
		send_header(len);
		for (int unsigned i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
	endtask

	function automatic logic [31:0] rand_len(input logic [31:0] maxv);
		logic [31:0] cap;
		cap = ($urandom_range(0, 7) == 0) ? 32'd40 : 32'd12;
		return $urandom_range(0, (maxv < cap) ? maxv : cap);
	endfunction

	// header bytes give no result, so also let the input register and output buffer settle after the last transfer
	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(input logic [31:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_max(v);
	endtask

	initial begin
		logic [31:0] m;
		board = new();
		hold_request = 1'b0;
		burst_left = 0;
		byte_count = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset maximum
		send_header(32'd0);
		send_header(32'd0);
		send_header(32'd1);
		send_byte(8'hFF);
		send_header(32'd2);
		send_byte(8'h00);
		send_byte(8'h80);
		send_header(32'd3);
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'hFE);

		// zero maximum: only empty frames pass
		write_max(32'd0);
		repeat (3) send_frame(32'd0);

		// widest maximum, with a long receiver hold-off to back the block up
		write_max(32'hFFFF_FFFF);
		hold_request = 1'b1;
		send_frame(32'd48);
		while (byte_count < 180)
			send_frame(rand_len(32'hFFFF_FFFF));

		// small maximum with lengths right at the limit
		m = $urandom_range(1, 6);
		write_max(m);
		send_frame(m);
		send_frame(32'd0);
		while (byte_count < 260)
			send_frame(rand_len(m));

		while (byte_count < 490) begin
			m = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
			write_max(m);
			if ($urandom_range(0, 2) == 0)
				hold_request = 1'b1;
			send_frame(m);
			repeat (6) send_frame(rand_len(m));
		end

		// oversize length just above the maximum, then the dead stream eats bytes
		write_max(32'hFFFF_FFFE);
		send_header(32'hFFFF_FFFF);
		repeat (24) send_byte(8'($urandom_range(0, 255)));

		drain_results();
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/lpd_pkg.sv
rtl/core/lpd_frame_fsm.sv
rtl/core/lpd_skid.sv
rtl/core/length_prefix_deframer_top.sv
tb/length_prefix_deframer_top_test.sv
